### hw/rtl/mctoc_pkg.sv
// Shared types and constants of the multi-case threshold output control block.
package mctoc_pkg;

	localparam int VAL_W      = 16;
	localparam int TIME_W     = 24;
	localparam int NUM_CH     = 3;
	localparam int CASE_IDX_W = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 56;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CASE_0 = 3'd0,
		REG_CASE_1 = 3'd1,
		REG_CASE_2 = 3'd2,
		REG_CASE_3 = 3'd3,
		REG_HYST   = 3'd4,
		REG_MIN_ON = 3'd5,
		REG_MAX_ON = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		LOGIC_OFF = 2'd0,
		LOGIC_AND = 2'd1,
		LOGIC_OR  = 2'd2
	} logic_code_t;

	typedef enum logic [1:0] {
		TEST_OFF      = 2'd0,
		TEST_AT_LEAST = 2'd1,
		TEST_AT_MOST  = 2'd2
	} test_code_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CHANGE_NONE = 2'd0,
		CHANGE_ON   = 2'd1,
		CHANGE_OFF  = 2'd2
	} change_t;

	typedef struct packed {
		logic                  is_on;
		logic [CASE_IDX_W-1:0] cur_case;
		logic [TIME_W-1:0]     on_time;
	} ctl_state_t;

endpackage

### hw/rtl/mctoc_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
interface mctoc_in_if;
	import mctoc_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic [VAL_W-1:0] value_x;
	logic [VAL_W-1:0] value_y;
	logic [VAL_W-1:0] value_z;
	modport source (output valid, operation, value_x, value_y, value_z, input ready);
	modport sink   (input valid, operation, value_x, value_y, value_z, output ready);
endinterface

interface mctoc_out_if;
	import mctoc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  output_on;
	logic [CASE_IDX_W-1:0] active_case;
	logic [1:0]            change;
	modport source (output valid, output_on, active_case, change, input ready);
	modport sink   (input valid, output_on, active_case, change, output ready);
endinterface

interface mctoc_cfg_if;
	import mctoc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/mctoc_cfg_regs.sv
// Configuration register file: case words, hysteresis and on-time limits.
module mctoc_cfg_regs #(
	parameter int NUM_CASES   = 4,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                                        clk,
	input  logic                                                        arst_n,
	mctoc_cfg_if.sink                                                   cfg,
	output logic [NUM_CASES-1:0][1:0]                                   case_logic,
	output logic [NUM_CASES-1:0][mctoc_pkg::NUM_CH-1:0][1:0]            case_test,
	output logic [NUM_CASES-1:0][mctoc_pkg::NUM_CH-1:0][VALUE_WIDTH-1:0] case_thr,
	output logic [mctoc_pkg::NUM_CH-1:0][VALUE_WIDTH-1:0]               hys,
	output logic [mctoc_pkg::TIME_W-1:0]                                min_on,
	output logic [mctoc_pkg::TIME_W-1:0]                                max_on
);
	import mctoc_pkg::*;

	logic wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_logic <= '0;
			case_test  <= '0;
			case_thr   <= '0;
			hys        <= '0;
			min_on     <= '0;
			max_on     <= TIME_MAX;
		end else if (wr_en) begin
			for (int c = 0; c < NUM_CASES; c++) begin
				if (cfg.index == CFG_IDX_W'(REG_CASE_0) + CFG_IDX_W'(c)) begin
					case_logic[c] <= cfg.data[1:0];
					for (int ch = 0; ch < NUM_CH; ch++) begin
						case_test[c][ch] <= cfg.data[2 + 2*ch +: 2];
						case_thr[c][ch]  <= cfg.data[8 + 16*ch +: VALUE_WIDTH];
					end
				end
			end
			if (cfg.index == REG_HYST) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					hys[ch] <= cfg.data[16*ch +: VALUE_WIDTH];
				end
			end
			if (cfg.index == REG_MIN_ON) begin
				min_on <= cfg.data[TIME_W-1:0];
			end
			if (cfg.index == REG_MAX_ON) begin
				max_on <= cfg.data[TIME_W-1:0];
			end
		end
	end

endmodule

### hw/rtl/mctoc_eval.sv
// Per-item decision logic: case matching while off, release checks while on, on-time counting on ticks.
module mctoc_eval #(
	parameter int NUM_CASES   = 4,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                                                        operation,
	input  logic [mctoc_pkg::NUM_CH-1:0][VALUE_WIDTH-1:0]               val,
	input  mctoc_pkg::ctl_state_t                                       cur_state,
	input  logic [NUM_CASES-1:0][1:0]                                   case_logic,
	input  logic [NUM_CASES-1:0][mctoc_pkg::NUM_CH-1:0][1:0]            case_test,
	input  logic [NUM_CASES-1:0][mctoc_pkg::NUM_CH-1:0][VALUE_WIDTH-1:0] case_thr,
	input  logic [mctoc_pkg::NUM_CH-1:0][VALUE_WIDTH-1:0]               hys,
	input  logic [mctoc_pkg::TIME_W-1:0]                                min_on,
	input  logic [mctoc_pkg::TIME_W-1:0]                                max_on,
	output mctoc_pkg::ctl_state_t                                       next_state,
	output mctoc_pkg::change_t                                          change
);
	import mctoc_pkg::*;

	logic                  hit;
	logic [CASE_IDX_W-1:0] hit_case;
	logic                  release_req;

	// Switch-on search over all configured cases; a later match overrides.
	always_comb begin
		logic [NUM_CH-1:0] met;
		logic              case_hit;
		hit      = 1'b0;
		hit_case = cur_state.cur_case;
		for (int c = 0; c < NUM_CASES; c++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				unique case (case_test[c][ch])
					TEST_OFF:      met[ch] = 1'b1;
					TEST_AT_LEAST: met[ch] = (val[ch] >= case_thr[c][ch]);
					TEST_AT_MOST:  met[ch] = (val[ch] <= case_thr[c][ch]);
					default:       met[ch] = 1'b0;
				endcase
			end
			unique case (case_logic[c])
				LOGIC_AND: case_hit = &met;
				LOGIC_OR:  case_hit = |met;
				default:   case_hit = 1'b0;
			endcase
			if (case_hit) begin
				hit      = 1'b1;
				hit_case = CASE_IDX_W'(c);
			end
		end
	end

	// Release check against the active case. Both sides are kept one bit wider,
	// so threshold minus hysteresis is compared as value plus hysteresis.
	always_comb begin
		logic [NUM_CH-1:0][1:0]             sel_test;
		logic [NUM_CH-1:0][VALUE_WIDTH-1:0] sel_thr;
		logic                               past_min;
		logic                               past_max;
		logic [VALUE_WIDTH:0]               val_plus;
		logic [VALUE_WIDTH:0]               thr_plus;
		sel_test    = '0;
		sel_thr     = '0;
		release_req = 1'b0;
		for (int c = 0; c < NUM_CASES; c++) begin
			if (cur_state.cur_case == CASE_IDX_W'(c)) begin
				sel_test = case_test[c];
				sel_thr  = case_thr[c];
			end
		end
		past_min = (cur_state.on_time > min_on);
		past_max = (cur_state.on_time > max_on);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			val_plus = {1'b0, val[ch]} + {1'b0, hys[ch]};
			thr_plus = {1'b0, sel_thr[ch]} + {1'b0, hys[ch]};
			unique case (sel_test[ch])
				TEST_AT_LEAST: begin
					if ((val_plus < {1'b0, sel_thr[ch]} && past_min) || past_max) begin
						release_req = 1'b1;
					end
				end
				TEST_AT_MOST: begin
					if (({1'b0, val[ch]} > thr_plus && past_min) || past_max) begin
						release_req = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		next_state = cur_state;
		change     = CHANGE_NONE;
		if (operation == OP_TICK) begin
			if (cur_state.is_on && cur_state.on_time != TIME_MAX) begin
				next_state.on_time = cur_state.on_time + TIME_W'(1);
			end
		end else if (!cur_state.is_on) begin
			if (hit) begin
				next_state.is_on    = 1'b1;
				next_state.cur_case = hit_case;
				next_state.on_time  = '0;
				change              = CHANGE_ON;
			end
		end else if (release_req) begin
			next_state.is_on   = 1'b0;
			next_state.on_time = '0;
			change             = CHANGE_OFF;
		end
	end

endmodule

### hw/rtl/multi_case_threshold_output_control_core.sv
// An accepted item passes the input register and then the result register before its result shows.
// Throughput: one item per cycle; while a result waits, the input register takes one more item
// and then holds the input off until the result transfer.
// The on/off state, active case and on-time update in the same cycle the result is registered.
// Reset (arst_n low) turns the output off, clears the active case and on-time, zeroes the
// case words, hysteresis and minimum on-time, and sets the maximum on-time to all ones.
module multi_case_threshold_output_control_core #(
	parameter int NUM_CASES   = 4,
	parameter int VALUE_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mctoc_in_if.sink     item,
	mctoc_out_if.source  result,
	mctoc_cfg_if.sink    cfg
);
	import mctoc_pkg::*;

	logic [NUM_CASES-1:0][1:0]                      case_logic;
	logic [NUM_CASES-1:0][NUM_CH-1:0][1:0]          case_test;
	logic [NUM_CASES-1:0][NUM_CH-1:0][VALUE_WIDTH-1:0] case_thr;
	logic [NUM_CH-1:0][VALUE_WIDTH-1:0]             hys;
	logic [TIME_W-1:0]                              min_on;
	logic [TIME_W-1:0]                              max_on;

	logic                               valid_s1;
	logic                               op_s1;
	logic [NUM_CH-1:0][VALUE_WIDTH-1:0] val_s1;
	logic                               valid_s2;
	logic                               output_on_s2;
	logic [CASE_IDX_W-1:0]              active_case_s2;
	change_t                            change_s2;

	ctl_state_t state_q;
	ctl_state_t next_state;
	change_t    change;
	logic       advance;

	mctoc_cfg_regs #(
		.NUM_CASES   (NUM_CASES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_cfg_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.case_logic (case_logic),
		.case_test  (case_test),
		.case_thr   (case_thr),
		.hys        (hys),
		.min_on     (min_on),
		.max_on     (max_on)
	);

	mctoc_eval #(
		.NUM_CASES   (NUM_CASES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_eval (
		.operation  (op_s1),
		.val        (val_s1),
		.cur_state  (state_q),
		.case_logic (case_logic),
		.case_test  (case_test),
		.case_thr   (case_thr),
		.hys        (hys),
		.min_on     (min_on),
		.max_on     (max_on),
		.next_state (next_state),
		.change     (change)
	);

	// The first stage moves on when the result register is empty or being drained.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1     <= item.operation;
			val_s1[0] <= item.value_x[VALUE_WIDTH-1:0];
			val_s1[1] <= item.value_y[VALUE_WIDTH-1:0];
			val_s1[2] <= item.value_z[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.is_on    <= 1'b0;
			state_q.cur_case <= '0;
			state_q.on_time  <= '0;
			valid_s2         <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= next_state;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			output_on_s2   <= next_state.is_on;
			active_case_s2 <= next_state.cur_case;
			change_s2      <= change;
		end
	end

	assign result.valid       = valid_s2;
	assign result.output_on   = output_on_s2;
	assign result.active_case = active_case_s2;
	assign result.change      = change_s2;

endmodule

### sim/tb_multi_case_threshold_output_control_core.sv
// Self-checking testbench for the multi-case threshold output control core.
module tb_multi_case_threshold_output_control_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mctoc_pkg::*;

	localparam logic [1:0] LOGIC_SPARE = 2'd3;
	localparam logic [1:0] TEST_NEVER  = 2'd3;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 240;
	localparam int SETTLE_CYCLES  = 4;
	localparam int HOLD_AFTER     = 400;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 1000000;

	typedef struct packed {
		logic       output_on;
		logic [1:0] active_case;
		change_t    change;
	} ctl_result_t;

	typedef struct {
		bit          is_reg;
		logic [2:0]  reg_idx;
		logic [55:0] reg_data;
		op_t         op;
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] vz;
		bit          typed;
		ctl_result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	mctoc_in_if  item_bus();
	mctoc_out_if result_bus();
	mctoc_cfg_if cfg_bus();

	multi_case_threshold_output_control_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Shadow of the block's registers and control state.
	logic [55:0] case_regs [4];
	logic [47:0] hyst_reg;
	logic [23:0] min_on_reg;
	logic [23:0] max_on_reg;
	logic        ctl_on;
	logic [1:0]  ctl_case;
	logic [23:0] ctl_time;

	ctl_result_t pending_results [$];
	plan_row_t   plan [$];

	int  fail_count   = 0;
	int  results_seen = 0;
	int  cycles       = 0;
	int  calm_left    = 0;
	bit  sink_holding = 0;
	bit  hold_done    = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(15, 60))
		                                   : int'($urandom_range(1, 3));
	endfunction

	function automatic logic [55:0] pack_case(logic [1:0] lg, logic [1:0] tx, logic [1:0] ty,
	                                          logic [1:0] tz, logic [15:0] hx, logic [15:0] hy,
	                                          logic [15:0] hz);
		return {hz, hy, hx, tz, ty, tx, lg};
	endfunction

	function automatic logic [55:0] random_case_word();
		int          pick;
		logic [1:0]  lg;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			lg = LOGIC_OFF;
		else if (pick == 1)
			lg = LOGIC_SPARE;
		else if (pick < 6)
			lg = LOGIC_AND;
		else
			lg = LOGIC_OR;
		return pack_case(lg, 2'($urandom), 2'($urandom), 2'($urandom),
		                 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	function automatic void set_register(logic [2:0] idx, logic [55:0] d);
		case (idx)
			REG_CASE_0, REG_CASE_1, REG_CASE_2, REG_CASE_3: begin
				case_regs[idx[1:0]] = d;
			end
			REG_HYST: begin
				hyst_reg = d[47:0];
			end
			REG_MIN_ON: begin
				min_on_reg = d[23:0];
			end
			REG_MAX_ON: begin
				max_on_reg = d[23:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Computes the result of one item and advances the shadow state.
	function automatic ctl_result_t next_control(op_t op, logic [15:0] vx, logic [15:0] vy,
	                                             logic [15:0] vz);
		int          vals [3];
		logic [55:0] w;
		logic [1:0]  lg;
		logic [1:0]  tc;
		int          th;
		int          hy;
		int          met;
		logic        hit;
		logic        rel;
		logic        past_min;
		logic        past_max;
		change_t     chg;
		ctl_result_t r;
		vals[0] = vx;
		vals[1] = vy;
		vals[2] = vz;
		chg = CHANGE_NONE;
		if (op == OP_TICK) begin
			if (ctl_on && ctl_time != TIME_MAX)
				ctl_time = ctl_time + 24'd1;
		end else if (!ctl_on) begin
			hit = 1'b0;
			for (int c = 0; c < 4; c++) begin
				w = case_regs[c];
				lg = w[1:0];
				if (lg == LOGIC_AND || lg == LOGIC_OR) begin
					met = 0;
					for (int ch = 0; ch < 3; ch++) begin
						tc = w[2*ch+2 +: 2];
						th = w[8+16*ch +: 16];
						if (tc == TEST_OFF || (tc == TEST_AT_LEAST && vals[ch] >= th) ||
						    (tc == TEST_AT_MOST && vals[ch] <= th))
							met++;
					end
					// The last matching case wins.
					if ((lg == LOGIC_AND && met == 3) || (lg == LOGIC_OR && met >= 1)) begin
						hit = 1'b1;
						ctl_case = 2'(c);
					end
				end
			end
			if (hit) begin
				ctl_on = 1'b1;
				ctl_time = '0;
				chg = CHANGE_ON;
			end
		end else begin
			// Release follows the active case's test codes even if its logic is now off.
			w = case_regs[ctl_case];
			rel = 1'b0;
			past_min = ctl_time > min_on_reg;
			past_max = ctl_time > max_on_reg;
			for (int ch = 0; ch < 3; ch++) begin
				tc = w[2*ch+2 +: 2];
				th = w[8+16*ch +: 16];
				hy = hyst_reg[16*ch +: 16];
				if (tc == TEST_AT_LEAST && ((vals[ch] < th - hy && past_min) || past_max))
					rel = 1'b1;
				if (tc == TEST_AT_MOST && ((vals[ch] > th + hy && past_min) || past_max))
					rel = 1'b1;
			end
			if (rel) begin
				ctl_on = 1'b0;
				ctl_time = '0;
				chg = CHANGE_OFF;
			end
		end
		r.output_on = ctl_on;
		r.active_case = ctl_case;
		r.change = chg;
		return r;
	endfunction

	function automatic plan_row_t item_row(op_t op, logic [15:0] x, logic [15:0] y,
	                                       logic [15:0] z);
		plan_row_t r;
		r.is_reg = 1'b0;
		r.reg_idx = REG_UNUSED;
		r.reg_data = '0;
		r.op = op;
		r.vx = x;
		r.vy = y;
		r.vz = z;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(op_t op, logic [15:0] x, logic [15:0] y,
	                                        logic [15:0] z, logic on, logic [1:0] cs,
	                                        change_t chg);
		plan_row_t r;
		r = item_row(op, x, y, z);
		r.typed = 1'b1;
		r.want = '{output_on: on, active_case: cs, change: chg};
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [2:0] idx, logic [55:0] d);
		plan_row_t r;
		r = item_row(OP_SAMPLE, '0, '0, '0);
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_data = d;
		return r;
	endfunction

	// Waits until every expected result has arrived, then lets the pipeline settle.
	task automatic drain_results();
		item_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [55:0] d);
		drain_results();
		cfg_bus.index <= idx;
		cfg_bus.data <= d;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		set_register(idx, d);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(op_t op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
	                         bit typed, ctl_result_t typed_want);
		ctl_result_t pred;
		item_bus.operation <= op;
		item_bus.value_x <= x;
		item_bus.value_y <= y;
		item_bus.value_z <= z;
		item_bus.valid <= 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		pred = next_control(op, x, y, z);
		pending_results.push_back(typed ? typed_want : pred);
	endtask

	task automatic configure_phase(int p);
		logic [55:0] words [4];
		logic [47:0] hy;
		logic [23:0] lo;
		logic [23:0] hi;
		for (int c = 0; c < 4; c++)
			words[c] = random_case_word();
		if ($urandom_range(0, 1) == 0)
			hy = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
			      16'($urandom_range(0, 300))};
		else
			hy = {16'($urandom), 16'($urandom), 16'($urandom)};
		lo = 24'($urandom_range(0, 6));
		hi = 24'($urandom_range(0, 30));
		case (p)
			0: begin
				lo = '0;
				hi = '0;
			end
			1: begin
				lo = TIME_MAX;
				hi = TIME_MAX;
			end
			2: begin
				words[0] = pack_case(LOGIC_AND, TEST_AT_LEAST, TEST_AT_LEAST, TEST_AT_LEAST,
				                     16'hFFFF, 16'hFFFF, 16'hFFFF);
				words[1] = pack_case(LOGIC_OR, TEST_AT_MOST, TEST_AT_MOST, TEST_AT_MOST,
				                     16'h0000, 16'h0000, 16'h0000);
				words[2] = pack_case(LOGIC_AND, TEST_AT_MOST, TEST_AT_LEAST, TEST_OFF,
				                     16'hFFFF, 16'h0000, 16'($urandom));
				hy = '1;
				lo = 24'($urandom_range(0, 4));
				hi = 24'($urandom_range(3, 20));
			end
			default: begin
			end
		endcase
		write_reg(REG_CASE_0, words[0]);
		write_reg(REG_CASE_1, words[1]);
		write_reg(REG_CASE_2, words[2]);
		write_reg(REG_CASE_3, words[3]);
		write_reg(REG_HYST, {8'($urandom), hy});
		write_reg(REG_MIN_ON, {32'($urandom), lo});
		write_reg(REG_MAX_ON, {32'($urandom), hi});
		write_reg(REG_UNUSED, {24'($urandom), 32'($urandom)});
	endtask

	task automatic random_item();
		logic [15:0] v [3];
		op_t         op;
		int          mode;
		int          c;
		int          th;
		int          span;
		op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_SAMPLE;
		mode = $urandom_range(0, 2);
		c = $urandom_range(0, 3);
		for (int ch = 0; ch < 3; ch++) begin
			if (mode == 0) begin
				v[ch] = 16'($urandom);
			end else if (mode == 1) begin
				// Land close to a threshold, inside or just past the hysteresis band.
				th = case_regs[c][8+16*ch +: 16];
				span = hyst_reg[16*ch +: 16];
				if (span > 64)
					span = 64;
				span = span + 2;
				v[ch] = 16'(th + int'($urandom_range(0, 2 * span)) - span);
			end else begin
				v[ch] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
			end
		end
		send_item(op, v[0], v[1], v[2], 1'b0, '0);
		if (sink_holding) begin
			// Keep offering so the block backs up against the stalled result side.
		end else if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(30, 80);
		end else if ($urandom_range(0, 2) == 0) begin
			item_bus.valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	initial begin
		int run;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				sink_holding = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_holding = 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				result_bus.ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		ctl_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result transfer with no expected result pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_bus.output_on !== want.output_on) begin
					$error("output_on: expected %0d, got %0d", want.output_on,
					       result_bus.output_on);
					fail_count++;
				end
				if (result_bus.active_case !== want.active_case) begin
					$error("active_case: expected %0d, got %0d", want.active_case,
					       result_bus.active_case);
					fail_count++;
				end
				if (result_bus.change !== want.change) begin
					$error("change: expected %0d, got %0d", want.change, result_bus.change);
					fail_count++;
				end
			end
		end
	end

	initial begin
		for (int c = 0; c < 4; c++)
			case_regs[c] = '0;
		hyst_reg = '0;
		min_on_reg = '0;
		max_on_reg = TIME_MAX;
		ctl_on = 1'b0;
		ctl_case = '0;
		ctl_time = '0;

		item_bus.valid = 1'b0;
		item_bus.operation = OP_SAMPLE;
		item_bus.value_x = '0;
		item_bus.value_y = '0;
		item_bus.value_z = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With every case off after reset nothing can switch on.
		plan.push_back(typed_row(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 2'd0, CHANGE_NONE));
		plan.push_back(typed_row(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0, CHANGE_NONE));
		plan.push_back(typed_row(OP_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 2'd0, CHANGE_NONE));
		plan.push_back(reg_row(REG_CASE_0, pack_case(LOGIC_AND, TEST_AT_LEAST, TEST_AT_MOST,
		                                             TEST_OFF, 16'h8000, 16'h1000, 16'h0000)));
		plan.push_back(reg_row(REG_HYST, {16'h0000, 16'h0010, 16'h0100}));
		plan.push_back(reg_row(REG_MIN_ON, 56'd1));
		plan.push_back(reg_row(REG_MAX_ON, 56'd3));
		plan.push_back(item_row(OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000));
		// Both tests met exactly at their thresholds.
		plan.push_back(typed_row(OP_SAMPLE, 16'h8000, 16'h1000, 16'hFFFF, 1'b1, 2'd0, CHANGE_ON));
		plan.push_back(item_row(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h0000));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		// Right at the edge of the hysteresis band, then one below it.
		plan.push_back(item_row(OP_SAMPLE, 16'h7F00, 16'h1000, 16'h0000));
		plan.push_back(typed_row(OP_SAMPLE, 16'h7EFF, 16'h1000, 16'h0000, 1'b0, 2'd0, CHANGE_OFF));
		plan.push_back(reg_row(REG_CASE_1, pack_case(LOGIC_SPARE, TEST_OFF, TEST_OFF, TEST_OFF,
		                                             16'h0000, 16'h0000, 16'h0000)));
		plan.push_back(reg_row(REG_CASE_3, pack_case(LOGIC_OR, TEST_NEVER, TEST_AT_LEAST,
		                                             TEST_AT_MOST, 16'h0000, 16'hFFFF, 16'h0000)));
		plan.push_back(reg_row(REG_HYST, {16'hFFFF, 16'h0010, 16'h0100}));
		plan.push_back(typed_row(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'h0005, 1'b1, 2'd3, CHANGE_ON));
		plan.push_back(item_row(OP_TICK, 16'h1234, 16'h5678, 16'h9ABC));
		plan.push_back(item_row(OP_TICK, 16'hEDCB, 16'hA987, 16'h6543));
		plan.push_back(item_row(OP_SAMPLE, 16'h0000, 16'hFFEF, 16'hFFFF));
		plan.push_back(item_row(OP_SAMPLE, 16'h0000, 16'hFFEE, 16'hFFFF));
		plan.push_back(reg_row(REG_CASE_2, pack_case(LOGIC_AND, TEST_AT_LEAST, TEST_OFF, TEST_OFF,
		                                             16'h0000, 16'h0000, 16'h0000)));
		plan.push_back(typed_row(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0005, 1'b1, 2'd2, CHANGE_ON));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		// Threshold minus hysteresis goes below zero, so no value can release; only the maximum on-time can.
		plan.push_back(item_row(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(typed_row(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 2'd2, CHANGE_OFF));
		plan.push_back(typed_row(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0005, 1'b1, 2'd2, CHANGE_ON));
		plan.push_back(reg_row(REG_CASE_2, pack_case(LOGIC_OFF, TEST_AT_MOST, TEST_OFF, TEST_OFF,
		                                             16'h0010, 16'h0000, 16'h0000)));
		plan.push_back(reg_row(REG_MIN_ON, 56'd0));
		plan.push_back(item_row(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
		plan.push_back(item_row(OP_SAMPLE, 16'h0111, 16'h0000, 16'h0000));

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].reg_idx, plan[i].reg_data);
			else
				send_item(plan[i].op, plan[i].vx, plan[i].vy, plan[i].vz, plan[i].typed,
				          plan[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			configure_phase(p);
			repeat (PHASE_ITEMS) random_item();
		end

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
